>>> src/wqle_pkg.sv
// Shared constants, types and arithmetic helpers of the weighted quadratic loss engine
`timescale 1ns / 1ps
`default_nettype none

package wqle_pkg;

   // number formats
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int SUM_W     = 2 * DATA_W;
   localparam int MUL_A_W   = 2 * DATA_W;
   localparam int PROD_W    = 3 * DATA_W;
   localparam int DIFF_W    = DATA_W + 1;
   localparam int T_W       = DATA_W + 2;
   localparam int CSR_IDX_W = 8;
   localparam int MODE_W    = 2;
   localparam int PSEL_W    = 3;
   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE           = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_USE_UNIFORM    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_UNIFORM_WEIGHT = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_OFFSET    = CSR_IDX_W'(3);

   // mode codes, the unused code behaves as the hessian product
   localparam logic [MODE_W-1:0] MODE_LOSS = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CONJ = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HESS = 2'd2;

   // product selects of the shared multiplier
   localparam logic [PSEL_W-1:0] PSEL_GRAD = 3'd0;
   localparam logic [PSEL_W-1:0] PSEL_SQ   = 3'd1;
   localparam logic [PSEL_W-1:0] PSEL_LOSS = 3'd2;
   localparam logic [PSEL_W-1:0] PSEL_CONJ = 3'd3;
   localparam logic [PSEL_W-1:0] PSEL_HESS = 3'd4;

   // reset values
   localparam logic [MODE_W-1:0] MODE_RESET           = MODE_LOSS;
   localparam logic [DATA_W-1:0] UNIFORM_WEIGHT_RESET = DATA_W'(1) << FRAC_BITS;

   // saturation limits
   localparam logic [DATA_W-1:0] MAX32 = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] MIN32 = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [SUM_W-1:0]  MAX64 = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0]  MIN64 = {1'b1, {(SUM_W-1){1'b0}}};

   // controller to datapath commands
   typedef struct packed {
      logic              load;
      logic              div_start;
      logic              div_step;
      logic              conj_q;
      logic              mul_lo;
      logic              mul_hi;
      logic              mul_sum;
      logic              take;
      logic              emit;
      logic [PSEL_W-1:0] psel;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              w_zero;
   } dp_status_type;

   // signed clamp of a sign and magnitude pair to the 32-bit range
   function automatic logic [DATA_W-1:0] clamp_mag(input logic neg,
                                                    input logic [PROD_W-1:0] mag);
      logic [DATA_W-1:0] res;
      if (!neg) begin
         res = (|mag[PROD_W-1:DATA_W-1]) ? MAX32 : mag[DATA_W-1:0];
      end else if ((|mag[PROD_W-1:DATA_W]) ||
                   (mag[DATA_W-1] && (|mag[DATA_W-2:0]))) begin
         res = MIN32;
      end else begin
         res = DATA_W'(0) - mag[DATA_W-1:0];
      end
      return res;
   endfunction

   // clamp of a two's complement value two bits wider than a data word
   function automatic logic [DATA_W-1:0] clamp_t(input logic [T_W-1:0] v);
      logic [DATA_W-1:0] res;
      if (!v[T_W-1] && (|v[T_W-2:DATA_W-1])) begin
         res = MAX32;
      end else if (v[T_W-1] && !(&v[T_W-2:DATA_W-1])) begin
         res = MIN32;
      end else begin
         res = v[DATA_W-1:0];
      end
      return res;
   endfunction

   // saturating two's complement add of the running sum
   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
      logic [SUM_W:0]   s;
      logic [SUM_W-1:0] res;
      s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
      if (s[SUM_W] != s[SUM_W-1]) begin
         res = s[SUM_W] ? MIN64 : MAX64;
      end else begin
         res = s[SUM_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> src/wqle_req_if.sv
// Input element channel of the weighted quadratic loss engine
`timescale 1ns / 1ps
`default_nettype none

interface wqle_req_if import wqle_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] element;
   logic        [DATA_W-1:0] weight;
   logic signed [DATA_W-1:0] offset;
   logic                     last;

   modport source (output valid, element, weight, offset, last, input ready);
   modport sink   (input valid, element, weight, offset, last, output ready);
endinterface

`default_nettype wire

>>> src/wqle_rsp_if.sv
// Result channel of the weighted quadratic loss engine
`timescale 1ns / 1ps
`default_nettype none

interface wqle_rsp_if import wqle_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] element_out;
   logic signed [SUM_W-1:0]  total;
   logic                     total_valid;
   logic                     div_zero;

   modport source (output valid, element_out, total, total_valid, div_zero, input ready);
   modport sink   (input valid, element_out, total, total_valid, div_zero, output ready);
endinterface

`default_nettype wire

>>> src/wqle_csr_if.sv
// Register write channel of the weighted quadratic loss engine
`timescale 1ns / 1ps
`default_nettype none

interface wqle_csr_if import wqle_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/wqle_ctrl.sv
// Sequencing state machine of the weighted quadratic loss engine
`timescale 1ns / 1ps
`default_nettype none

module wqle_ctrl import wqle_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] S_IDLE     = 4'd0;
   localparam logic [STATE_W-1:0] S_DISPATCH = 4'd1;
   localparam logic [STATE_W-1:0] S_DIV      = 4'd2;
   localparam logic [STATE_W-1:0] S_CONJ_Q   = 4'd3;
   localparam logic [STATE_W-1:0] S_MUL_LO   = 4'd4;
   localparam logic [STATE_W-1:0] S_MUL_HI   = 4'd5;
   localparam logic [STATE_W-1:0] S_MUL_SUM  = 4'd6;
   localparam logic [STATE_W-1:0] S_TAKE     = 4'd7;
   localparam logic [STATE_W-1:0] S_EMIT     = 4'd8;

   logic [STATE_W-1:0]   state_ff, state_in;
   logic [PSEL_W-1:0]    psel_ff, psel_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 out_valid_ff, out_valid_in;

   // next state and command decode
   always_comb begin
      state_in   = state_ff;
      psel_in    = psel_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      cmd.psel   = psel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (status.mode)
               MODE_LOSS: begin
                  psel_in  = PSEL_GRAD;
                  state_in = S_MUL_LO;
               end
               MODE_CONJ: begin
                  if (status.w_zero) begin
                     state_in = S_CONJ_Q;
                  end else begin
                     cmd.div_start = 1'b1;
                     div_cnt_in    = '0;
                     state_in      = S_DIV;
                  end
               end
               default: begin
                  psel_in  = PSEL_HESS;
                  state_in = S_MUL_LO;
               end
            endcase
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_CONJ_Q;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         S_CONJ_Q: begin
            cmd.conj_q = 1'b1;
            psel_in    = PSEL_CONJ;
            state_in   = S_MUL_LO;
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_MUL_SUM;
         end
         S_MUL_SUM: begin
            cmd.mul_sum = 1'b1;
            state_in    = S_TAKE;
         end
         S_TAKE: begin
            cmd.take = 1'b1;
            if (psel_ff == PSEL_GRAD) begin
               psel_in  = PSEL_SQ;
               state_in = S_MUL_LO;
            end else if (psel_ff == PSEL_SQ) begin
               psel_in  = PSEL_LOSS;
               state_in = S_MUL_LO;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output beat valid
   always_comb begin
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         psel_ff      <= PSEL_GRAD;
         div_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         psel_ff      <= psel_in;
         div_cnt_ff   <= div_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

>>> src/wqle_dp.sv
// Datapath: config registers, shared multiplier, radix-2 divider, sum and output registers
`timescale 1ns / 1ps
`default_nettype none

module wqle_dp import wqle_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   input  logic [DATA_W-1:0]    req_element,
   input  logic [DATA_W-1:0]    req_weight,
   input  logic [DATA_W-1:0]    req_offset,
   input  logic                 req_last,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data,
   output logic [DATA_W-1:0]    rsp_element_out,
   output logic [SUM_W-1:0]     rsp_total,
   output logic                 rsp_total_valid,
   output logic                 rsp_div_zero
);

   // config registers
   logic [MODE_W-1:0] cfg_mode_ff, cfg_mode_in;
   logic              cfg_use_uniform_ff, cfg_use_uniform_in;
   logic [DATA_W-1:0] cfg_uniform_weight_ff, cfg_uniform_weight_in;
   logic              cfg_zero_offset_ff, cfg_zero_offset_in;

   // item operands
   logic [DATA_W-1:0] x_ff, x_in;
   logic [DATA_W-1:0] w_ff, w_in;
   logic [DATA_W-1:0] p_ff, p_in;
   logic              last_ff, last_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [DATA_W-1:0] ad_ff, ad_in;
   logic              d_neg_ff, d_neg_in;
   logic [DATA_W-1:0] ax_ff, ax_in;

   // intermediate results
   logic [SUM_W-1:0]  sq_ff, sq_in;
   logic [T_W-1:0]    t_mag_ff, t_mag_in;
   logic              t_neg_ff, t_neg_in;
   logic [DATA_W-1:0] elem_ff, elem_in;
   logic              dz_ff, dz_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   // multiplier
   logic [SUM_W-1:0]   pp_lo_ff, pp_lo_in;
   logic [SUM_W-1:0]   pp_hi_ff, pp_hi_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [MUL_A_W-1:0] mul_a;
   logic [DATA_W-1:0]  mul_b;

   // divider
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvd_ff, dvd_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic              div_ovf_ff, div_ovf_in;

   // output beat registers
   logic [DATA_W-1:0] out_elem_ff, out_elem_in;
   logic [SUM_W-1:0]  out_total_ff, out_total_in;
   logic              out_total_valid_ff, out_total_valid_in;
   logic              out_dz_ff, out_dz_in;

   // load-time values
   logic [DATA_W-1:0] w_sel, p_sel;
   logic [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0] diff_mag;
   logic [DATA_W-1:0] div_hi;

   // divide step
   logic [DATA_W:0]   rem_shift;
   logic              rem_ge;

   // quotient post-processing
   logic              x_neg, x_zero;
   logic [DATA_W-1:0] q;
   logic [T_W-1:0]    q_ext, p_ext, pq_sum, t_val;

   // term of the running sum
   logic [PROD_W-1:0] loss_shift;
   logic [SUM_W-1:0]  loss_term;
   logic [SUM_W-1:0]  conj_mag;
   logic [SUM_W-1:0]  conj_term;

   assign x_neg  = x_ff[DATA_W-1];
   assign x_zero = ~|x_ff;

   // multiplier operand select
   always_comb begin
      unique case (cmd.psel)
         PSEL_GRAD: begin
            mul_a = MUL_A_W'(ad_ff);
            mul_b = w_ff;
         end
         PSEL_SQ: begin
            mul_a = MUL_A_W'(ad_ff);
            mul_b = ad_ff;
         end
         PSEL_LOSS: begin
            mul_a = sq_ff;
            mul_b = w_ff;
         end
         PSEL_CONJ: begin
            mul_a = MUL_A_W'(t_mag_ff);
            mul_b = ax_ff;
         end
         default: begin
            mul_a = MUL_A_W'(ax_ff);
            mul_b = w_ff;
         end
      endcase
   end

   // load-time operand preparation
   always_comb begin
      w_sel    = cfg_use_uniform_ff ? cfg_uniform_weight_ff : req_weight;
      p_sel    = cfg_zero_offset_ff ? '0 : req_offset;
      diff     = {req_element[DATA_W-1], req_element} - {p_sel[DATA_W-1], p_sel};
      diff_mag = diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;
      div_hi   = ax_ff >> (DATA_W - FRAC_BITS);
   end

   // one restoring divide step
   always_comb begin
      rem_shift = {rem_ff, dvd_ff[DATA_W-1]};
      rem_ge    = (rem_shift >= {1'b0, w_ff});
   end

   // quotient clamp and conjugate terms
   always_comb begin
      if (w_ff == '0) begin
         q = x_zero ? '0 : (x_neg ? MIN32 : MAX32);
      end else if (div_ovf_ff) begin
         q = x_neg ? MIN32 : MAX32;
      end else begin
         q = clamp_mag(x_neg, PROD_W'(quo_ff));
      end
      q_ext  = {{(T_W-DATA_W){q[DATA_W-1]}}, q};
      p_ext  = {{(T_W-DATA_W){p_ff[DATA_W-1]}}, p_ff};
      pq_sum = p_ext + q_ext;
      t_val  = q_ext + {p_ff[DATA_W-1], p_ff, 1'b0};
   end

   // sum terms from the finished product
   always_comb begin
      loss_shift = prod_ff >> (FRAC_BITS + 1);
      loss_term  = (|loss_shift[PROD_W-1:SUM_W-1]) ? MAX64 : loss_shift[SUM_W-1:0];
      conj_mag   = prod_ff[SUM_W:1];
      conj_term  = (x_neg ^ t_neg_ff) ? (SUM_W'(0) - conj_mag) : conj_mag;
   end

   // register next values
   always_comb begin
      cfg_mode_in           = cfg_mode_ff;
      cfg_use_uniform_in    = cfg_use_uniform_ff;
      cfg_uniform_weight_in = cfg_uniform_weight_ff;
      cfg_zero_offset_in    = cfg_zero_offset_ff;
      x_in        = x_ff;
      w_in        = w_ff;
      p_in        = p_ff;
      last_in     = last_ff;
      mode_in     = mode_ff;
      ad_in       = ad_ff;
      d_neg_in    = d_neg_ff;
      ax_in       = ax_ff;
      sq_in       = sq_ff;
      t_mag_in    = t_mag_ff;
      t_neg_in    = t_neg_ff;
      elem_in     = elem_ff;
      dz_in       = dz_ff;
      sum_in      = sum_ff;
      pp_lo_in    = pp_lo_ff;
      pp_hi_in    = pp_hi_ff;
      prod_in     = prod_ff;
      rem_in      = rem_ff;
      dvd_in      = dvd_ff;
      quo_in      = quo_ff;
      div_ovf_in  = div_ovf_ff;
      out_elem_in        = out_elem_ff;
      out_total_in       = out_total_ff;
      out_total_valid_in = out_total_valid_ff;
      out_dz_in          = out_dz_ff;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            REG_MODE:           cfg_mode_in           = csr_data[MODE_W-1:0];
            REG_USE_UNIFORM:    cfg_use_uniform_in    = csr_data[0];
            REG_UNIFORM_WEIGHT: cfg_uniform_weight_in = csr_data;
            REG_ZERO_OFFSET:    cfg_zero_offset_in    = csr_data[0];
            default: begin
            end
         endcase
      end

      // capture the input beat
      if (cmd.load) begin
         x_in     = req_element;
         w_in     = w_sel;
         p_in     = p_sel;
         last_in  = req_last;
         mode_in  = cfg_mode_ff;
         ad_in    = diff_mag[DATA_W-1:0];
         d_neg_in = diff[DIFF_W-1];
         ax_in    = req_element[DATA_W-1] ? (DATA_W'(0) - req_element) : req_element;
         dz_in    = 1'b0;
      end

      // divider setup and steps
      if (cmd.div_start) begin
         rem_in     = div_hi;
         dvd_in     = ax_ff << FRAC_BITS;
         div_ovf_in = (div_hi >= w_ff);
      end
      if (cmd.div_step) begin
         rem_in = rem_ge ? DATA_W'(rem_shift - {1'b0, w_ff}) : rem_shift[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], rem_ge};
         dvd_in = {dvd_ff[DATA_W-2:0], 1'b0};
      end

      // conjugate element and its sum factor
      if (cmd.conj_q) begin
         elem_in  = clamp_t(pq_sum);
         t_neg_in = t_val[T_W-1];
         t_mag_in = t_val[T_W-1] ? (T_W'(0) - t_val) : t_val;
         dz_in    = (w_ff == '0);
      end

      // shared multiplier, two partial products then their sum
      if (cmd.mul_lo) begin
         pp_lo_in = mul_a[DATA_W-1:0] * mul_b;
      end
      if (cmd.mul_hi) begin
         pp_hi_in = mul_a[MUL_A_W-1:DATA_W] * mul_b;
      end
      if (cmd.mul_sum) begin
         prod_in = PROD_W'(pp_lo_ff) + {pp_hi_ff, {DATA_W{1'b0}}};
      end

      // use the finished product
      if (cmd.take) begin
         unique case (cmd.psel)
            PSEL_GRAD: elem_in = clamp_mag(d_neg_ff, prod_ff >> FRAC_BITS);
            PSEL_SQ:   sq_in   = prod_ff[SUM_W-1:0];
            PSEL_LOSS: sum_in  = sat_add(sum_ff, loss_term);
            PSEL_CONJ: sum_in  = sat_add(sum_ff, conj_term);
            default:   elem_in = clamp_mag(x_neg, prod_ff >> FRAC_BITS);
         endcase
      end

      // result beat, the sum leaves and clears on the last element
      if (cmd.emit) begin
         out_elem_in        = elem_ff;
         out_total_in       = last_ff ? sum_ff : '0;
         out_total_valid_in = last_ff;
         out_dz_in          = dz_ff;
         if (last_ff) begin
            sum_in = '0;
         end
      end
   end

   // config registers and the running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_mode_ff           <= MODE_RESET;
         cfg_use_uniform_ff    <= 1'b1;
         cfg_uniform_weight_ff <= UNIFORM_WEIGHT_RESET;
         cfg_zero_offset_ff    <= 1'b1;
         sum_ff                <= '0;
      end else begin
         cfg_mode_ff           <= cfg_mode_in;
         cfg_use_uniform_ff    <= cfg_use_uniform_in;
         cfg_uniform_weight_ff <= cfg_uniform_weight_in;
         cfg_zero_offset_ff    <= cfg_zero_offset_in;
         sum_ff                <= sum_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      w_ff       <= w_in;
      p_ff       <= p_in;
      last_ff    <= last_in;
      mode_ff    <= mode_in;
      ad_ff      <= ad_in;
      d_neg_ff   <= d_neg_in;
      ax_ff      <= ax_in;
      sq_ff      <= sq_in;
      t_mag_ff   <= t_mag_in;
      t_neg_ff   <= t_neg_in;
      elem_ff    <= elem_in;
      dz_ff      <= dz_in;
      pp_lo_ff   <= pp_lo_in;
      pp_hi_ff   <= pp_hi_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      quo_ff     <= quo_in;
      div_ovf_ff <= div_ovf_in;
      out_elem_ff        <= out_elem_in;
      out_total_ff       <= out_total_in;
      out_total_valid_ff <= out_total_valid_in;
      out_dz_ff          <= out_dz_in;
   end

   assign status.mode   = mode_ff;
   assign status.w_zero = (w_ff == '0);

   assign rsp_element_out = out_elem_ff;
   assign rsp_total       = out_total_ff;
   assign rsp_total_valid = out_total_valid_ff;
   assign rsp_div_zero    = out_dz_ff;

endmodule

`default_nettype wire

>>> src/weighted_quadratic_loss_engine.sv
// Top level of the weighted quadratic loss engine
//
// Usage: elements arrive on req_chan (element, weight, offset, last), one
// result beat per element leaves on rsp_chan (element_out, total,
// total_valid, div_zero). Registers are written on csr_chan (index 0 mode,
// 1 use_uniform_weight, 2 uniform_weight, 3 zero_offset; other indexes are
// dropped), always ready. The user must write registers only while the
// engine is idle; the block does not enforce this. One element is in work
// at a time. Loss mode makes three passes of the shared 32x32 multiplier,
// conjugate mode runs the 32-step radix-2 divider and then one product
// (the divider is skipped when the weight is zero), hessian mode makes one
// product. A new element is taken in the cycle after the result register
// is loaded; the divider loop sets the conjugate rate.
// Reset (synchronous) restores the register defaults, clears the running
// sum and drops any pending beat. When rsp_chan stalls the finished beat
// holds in the output register; the engine still accepts and works on the
// next element and waits only to hand over its result.
`timescale 1ns / 1ps
`default_nettype none

module weighted_quadratic_loss_engine import wqle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   wqle_req_if.sink   req_chan,
   wqle_rsp_if.source rsp_chan,
   wqle_csr_if.sink   csr_chan
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer
   wqle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and storage
   wqle_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_element     (req_chan.element),
      .req_weight      (req_chan.weight),
      .req_offset      (req_chan.offset),
      .req_last        (req_chan.last),
      .csr_valid       (csr_chan.valid),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .rsp_element_out (rsp_chan.element_out),
      .rsp_total       (rsp_chan.total),
      .rsp_total_valid (rsp_chan.total_valid),
      .rsp_div_zero    (rsp_chan.div_zero)
   );

   // register writes never stall
   assign csr_chan.ready = 1'b1;

   // total reads zero on every beat that is not the last one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.total_valid) |-> (rsp_chan.total == '0))
      else $error("total nonzero on a beat without total_valid");

   // one element at a time: an accepted beat closes the input
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("input still open after an accepted beat");

   // a new result only comes out of work, never straight from idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(!req_chan.ready))
      else $error("result beat raised while the engine was idle");

endmodule

`default_nettype wire
